// File: src/lbfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_pkg
// Shared types, widths and helpers of the four-vector boost pipeline.
// ----------------------------------------------------------------------------
package lbfv_pkg;

  // Field and register widths
  localparam int unsigned FIX_W  = 32;
  localparam int unsigned TOL_W  = 16;

  // Square root unit: 64-bit radicand, 32-bit floored root
  localparam int unsigned ROOT_IN_W  = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SQRT_STEPS = 2;

  // Divider: quotient magnitude limited to 2^(QUO_W-1)
  localparam int unsigned DEN_W     = 32;
  localparam int unsigned QUO_W     = 41;
  localparam int unsigned DIV_STEPS = 2;

  // Datapath widths
  localparam int unsigned DOT_W   = 66;
  localparam int unsigned PROD_W  = 73;
  localparam int unsigned INNER_W = 42;
  localparam int unsigned SPLIT   = 24;
  localparam int unsigned PL_W    = FIX_W + SPLIT + 1;
  localparam int unsigned PH_W    = FIX_W + INNER_W - SPLIT;
  localparam int unsigned SUM_W   = QUO_W + 2;

  typedef logic signed [FIX_W-1:0] fix_t;

  typedef enum logic [1:0] {
    ST_BOOST    = 2'd0,
    ST_REST     = 2'd1,
    ST_MASSLESS = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef struct packed {
    fix_t e;
    fix_t x;
    fix_t y;
    fix_t z;
  } fvec_t;

  // Carried alongside the square roots
  typedef struct packed {
    fvec_t                    part;
    fvec_t                    frame;
    logic signed [DOT_W-1:0]  dot;
    logic signed [DOT_W-1:0]  nume;
    logic                     ef_pos;
    logic                     spacelike;
    logic                     rest;
  } sq_side_t;

  // Carried alongside the first division
  typedef struct packed {
    fvec_t                    part;
    fix_t                     fx;
    fix_t                     fy;
    fix_t                     fz;
    logic signed [DOT_W-1:0]  nume;
    logic [DEN_W-1:0]         m;
    status_t                  st;
  } da_side_t;

  // Carried alongside the final division bank
  typedef struct packed {
    fvec_t   part;
    status_t st;
  } db_side_t;

  // True when the value does not fit the 32-bit field range
  function automatic logic sat_hit(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-FIX_W:0] top;
    top = v[SUM_W-1:FIX_W-1];
    return !((&top) || !(|top));
  endfunction

  // Clamp to the 32-bit field range
  function automatic fix_t sat_clip(input logic signed [SUM_W-1:0] v);
    fix_t r;
    if (sat_hit(v)) begin
      r = v[SUM_W-1] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/lbfv_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_in_if
// Input channel: particle and frame four-momenta with valid/ready.
// ----------------------------------------------------------------------------
interface lbfv_in_if;
  logic            valid;
  logic            ready;
  lbfv_pkg::fix_t  particle_energy;
  lbfv_pkg::fix_t  particle_mom_x;
  lbfv_pkg::fix_t  particle_mom_y;
  lbfv_pkg::fix_t  particle_mom_z;
  lbfv_pkg::fix_t  frame_energy;
  lbfv_pkg::fix_t  frame_mom_x;
  lbfv_pkg::fix_t  frame_mom_y;
  lbfv_pkg::fix_t  frame_mom_z;

  modport source (
    output valid, particle_energy, particle_mom_x, particle_mom_y, particle_mom_z,
           frame_energy, frame_mom_x, frame_mom_y, frame_mom_z,
    input  ready
  );
  modport sink (
    input  valid, particle_energy, particle_mom_x, particle_mom_y, particle_mom_z,
           frame_energy, frame_mom_x, frame_mom_y, frame_mom_z,
    output ready
  );
endinterface

// File: src/lbfv_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_out_if
// Result channel: boosted four-momentum and status with valid/ready.
// ----------------------------------------------------------------------------
interface lbfv_out_if;
  logic            valid;
  logic            ready;
  lbfv_pkg::fix_t  boosted_energy;
  lbfv_pkg::fix_t  boosted_mom_x;
  lbfv_pkg::fix_t  boosted_mom_y;
  lbfv_pkg::fix_t  boosted_mom_z;
  logic [1:0]      status;

  modport source (
    output valid, boosted_energy, boosted_mom_x, boosted_mom_y, boosted_mom_z, status,
    input  ready
  );
  modport sink (
    input  valid, boosted_energy, boosted_mom_x, boosted_mom_y, boosted_mom_z, status,
    output ready
  );
endinterface

// File: src/lbfv_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_sqrt_pipe
// Pipelined digit-by-digit floored square root, several lanes in lockstep,
// SQRT_STEPS root bits per stage, with a sideband word carried along.
// ----------------------------------------------------------------------------
module lbfv_sqrt_pipe #(
  parameter int LANES  = 2,
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [lbfv_pkg::ROOT_IN_W-1:0]      in_rad [LANES],
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_valid,
  output logic [lbfv_pkg::ROOT_W-1:0]         out_root [LANES],
  output logic [SIDE_W-1:0]                   out_side
);

  localparam int IN_W  = lbfv_pkg::ROOT_IN_W;
  localparam int RW    = lbfv_pkg::ROOT_W;
  localparam int REM_W = RW + 2;
  localparam int STEPS = lbfv_pkg::SQRT_STEPS;
  localparam int NSTG  = (RW + STEPS - 1) / STEPS;

  logic              vld_r  [NSTG];
  logic [SIDE_W-1:0] side_r [NSTG];
  logic [IN_W-1:0]   rad_r  [NSTG][LANES];
  logic [REM_W-1:0]  rem_r  [NSTG][LANES];
  logic [RW-1:0]     root_r [NSTG][LANES];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic              vld_in;
    logic [SIDE_W-1:0] side_in;
    logic [IN_W-1:0]   rad_in   [LANES];
    logic [REM_W-1:0]  rem_in   [LANES];
    logic [RW-1:0]     root_in  [LANES];
    logic [IN_W-1:0]   rad_nxt  [LANES];
    logic [REM_W-1:0]  rem_nxt  [LANES];
    logic [RW-1:0]     root_nxt [LANES];

    // Select stage source
    if (s == 0) begin : g_head
      always_comb begin
        vld_in  = in_valid;
        side_in = in_side;
        for (int l = 0; l < LANES; l++) begin
          rad_in[l]  = in_rad[l];
          rem_in[l]  = '0;
          root_in[l] = '0;
        end
      end
    end else begin : g_body
      always_comb begin
        vld_in  = vld_r[s-1];
        side_in = side_r[s-1];
        for (int l = 0; l < LANES; l++) begin
          rad_in[l]  = rad_r[s-1][l];
          rem_in[l]  = rem_r[s-1][l];
          root_in[l] = root_r[s-1][l];
        end
      end
    end

    // Resolve this stage's root bits
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rad_nxt[l]  = rad_in[l];
        rem_nxt[l]  = rem_in[l];
        root_nxt[l] = root_in[l];
        for (int j = 0; j < STEPS; j++) begin
          if (s * STEPS + j < RW) begin
            rem_nxt[l] = {rem_nxt[l][REM_W-3:0], rad_nxt[l][IN_W-1 -: 2]};
            rad_nxt[l] = rad_nxt[l] << 2;
            if (rem_nxt[l] >= {root_nxt[l], 2'b01}) begin
              rem_nxt[l]  = rem_nxt[l] - {root_nxt[l], 2'b01};
              root_nxt[l] = {root_nxt[l][RW-2:0], 1'b1};
            end else begin
              root_nxt[l] = {root_nxt[l][RW-2:0], 1'b0};
            end
          end
        end
      end
    end

    // Advance stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s]  <= vld_in;
        side_r[s] <= side_in;
        rad_r[s]  <= rad_nxt;
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];
  assign out_root  = root_r[NSTG-1];

endmodule

// File: src/lbfv_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_div_pipe
// Pipelined signed-by-positive restoring divider, truncating toward zero,
// quotient magnitude clamped to 2^(QUO_W-1). Lanes share one divisor.
// ----------------------------------------------------------------------------
module lbfv_div_pipe #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 66,
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [NUM_W-1:0]            in_num [LANES],
  input  logic [lbfv_pkg::DEN_W-1:0]         in_den,
  input  logic [SIDE_W-1:0]                  in_side,
  output logic                               out_valid,
  output logic signed [lbfv_pkg::QUO_W:0]    out_quo [LANES],
  output logic [SIDE_W-1:0]                  out_side
);

  localparam int DW    = lbfv_pkg::DEN_W;
  localparam int QW    = lbfv_pkg::QUO_W;
  localparam int STEPS = lbfv_pkg::DIV_STEPS;
  localparam int NSTG  = (QW + STEPS - 1) / STEPS;
  localparam logic [QW-1:0] LIM = {1'b1, {(QW-1){1'b0}}};

  // Entry stage: magnitude, sign and overflow check
  logic [NUM_W-1:0]  mag_c [LANES];
  logic [NUM_W-1:0]  hi_c  [LANES];
  logic              pre_vld_r;
  logic [SIDE_W-1:0] pre_side_r;
  logic [DW-1:0]     pre_den_r;
  logic              pre_neg_r [LANES];
  logic              pre_big_r [LANES];
  logic [DW-1:0]     pre_rem_r [LANES];
  logic [QW-1:0]     pre_quo_r [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag_c[l] = in_num[l][NUM_W-1] ? (~in_num[l] + 1'b1) : in_num[l];
      hi_c[l]  = mag_c[l] >> QW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r  <= in_valid;
      pre_side_r <= in_side;
      pre_den_r  <= in_den;
      for (int l = 0; l < LANES; l++) begin
        pre_neg_r[l] <= in_num[l][NUM_W-1];
        pre_big_r[l] <= hi_c[l] >= NUM_W'(in_den);
        pre_rem_r[l] <= hi_c[l][DW-1:0];
        pre_quo_r[l] <= mag_c[l][QW-1:0];
      end
    end
  end

  // Quotient stages
  logic              vld_r  [NSTG];
  logic [SIDE_W-1:0] side_r [NSTG];
  logic [DW-1:0]     den_r  [NSTG];
  logic              neg_r  [NSTG][LANES];
  logic              big_r  [NSTG][LANES];
  logic [DW-1:0]     rem_r  [NSTG][LANES];
  logic [QW-1:0]     quo_r  [NSTG][LANES];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic              vld_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW-1:0]     den_in;
    logic              neg_in  [LANES];
    logic              big_in  [LANES];
    logic [DW-1:0]     rem_in  [LANES];
    logic [QW-1:0]     quo_in  [LANES];
    logic [DW-1:0]     rem_nxt [LANES];
    logic [QW-1:0]     quo_nxt [LANES];
    logic [DW:0]       trial   [LANES];

    if (s == 0) begin : g_head
      always_comb begin
        vld_in  = pre_vld_r;
        side_in = pre_side_r;
        den_in  = pre_den_r;
        neg_in  = pre_neg_r;
        big_in  = pre_big_r;
        rem_in  = pre_rem_r;
        quo_in  = pre_quo_r;
      end
    end else begin : g_body
      always_comb begin
        vld_in  = vld_r[s-1];
        side_in = side_r[s-1];
        den_in  = den_r[s-1];
        neg_in  = neg_r[s-1];
        big_in  = big_r[s-1];
        rem_in  = rem_r[s-1];
        quo_in  = quo_r[s-1];
      end
    end

    // Shift in dividend bits, subtract where the divisor fits
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem_nxt[l] = rem_in[l];
        quo_nxt[l] = quo_in[l];
        trial[l]   = '0;
        for (int j = 0; j < STEPS; j++) begin
          if (s * STEPS + j < QW) begin
            trial[l]   = {rem_nxt[l], quo_nxt[l][QW-1]};
            quo_nxt[l] = quo_nxt[l] << 1;
            if (trial[l] >= {1'b0, den_in}) begin
              trial[l]      = trial[l] - {1'b0, den_in};
              quo_nxt[l][0] = 1'b1;
            end
            rem_nxt[l] = trial[l][DW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s]  <= vld_in;
        side_r[s] <= side_in;
        den_r[s]  <= den_in;
        neg_r[s]  <= neg_in;
        big_r[s]  <= big_in;
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
      end
    end
  end

  // Clamp and restore sign
  logic              fin_vld_r;
  logic [SIDE_W-1:0] fin_side_r;
  logic signed [QW:0] fin_quo_r [LANES];
  logic [QW-1:0]      qm_c      [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qm_c[l] = (big_r[NSTG-1][l] || quo_r[NSTG-1][l] > LIM) ? LIM : quo_r[NSTG-1][l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r  <= vld_r[NSTG-1];
      fin_side_r <= side_r[NSTG-1];
      for (int l = 0; l < LANES; l++) begin
        fin_quo_r[l] <= neg_r[NSTG-1][l] ? -$signed({1'b0, qm_c[l]})
                                         : $signed({1'b0, qm_c[l]});
      end
    end
  end

  assign out_valid = fin_vld_r;
  assign out_side  = fin_side_r;
  assign out_quo   = fin_quo_r;

endmodule

// File: src/lorentz_boost_four_vector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorentz_boost_four_vector_unit
// Boosts a particle four-momentum into the rest frame of a second
// four-momentum, signed fixed point, saturating, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | particle and frame four-momenta, 8 x 32b
//  out_ch   | out | valid/ready   | boosted four-momentum 4 x 32b, status 2b
//  cfg_     | in  | cfg_we        | lightlike tolerance, 16b
//
// One item enters per cycle while out_ch is not stalled; the 16-stage square
// root and two 23-stage dividers (two quotient bits a stage) lie in series.
// Reset (synchronous, active low) clears all stage valid bits and loads the
// tolerance reset value. A stall on out_ch freezes the whole pipeline;
// in_ch.ready is low only while a result waits to be taken.
// ----------------------------------------------------------------------------
module lorentz_boost_four_vector_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lbfv_pkg::TOL_W-1:0]   cfg_wdata,
  lbfv_in_if.sink                      in_ch,
  lbfv_out_if.source                   out_ch
);

  localparam longint unsigned TOL_RAW =
    ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [lbfv_pkg::TOL_W-1:0] TOL_RESET =
    (TOL_RAW == 0) ? 16'd1 : (TOL_RAW > 65535) ? 16'hFFFF : 16'(TOL_RAW);

  localparam int DOT_W   = lbfv_pkg::DOT_W;
  localparam int PROD_W  = lbfv_pkg::PROD_W;
  localparam int DEN_W   = lbfv_pkg::DEN_W;
  localparam int QUO_W   = lbfv_pkg::QUO_W;
  localparam int INNER_W = lbfv_pkg::INNER_W;
  localparam int SPLIT   = lbfv_pkg::SPLIT;
  localparam int PL_W    = lbfv_pkg::PL_W;
  localparam int PH_W    = lbfv_pkg::PH_W;
  localparam int SUM_W   = lbfv_pkg::SUM_W;
  localparam int RIN_W   = lbfv_pkg::ROOT_IN_W;

  logic en;
  logic out_vld_r;

  // Whole pipeline advances unless a result is held
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Tolerance register
  logic [lbfv_pkg::TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // Stage 1: squares and products
  logic                  s1_vld_r;
  lbfv_pkg::fvec_t       s1_part_r, s1_frame_r;
  logic [62:0]           s1_sq_r [4];
  logic signed [63:0]    s1_pr_r [4];
  logic signed [63:0]    sq_c [4];
  logic signed [63:0]    pr_c [4];

  always_comb begin
    sq_c[0] = in_ch.frame_energy * in_ch.frame_energy;
    sq_c[1] = in_ch.frame_mom_x * in_ch.frame_mom_x;
    sq_c[2] = in_ch.frame_mom_y * in_ch.frame_mom_y;
    sq_c[3] = in_ch.frame_mom_z * in_ch.frame_mom_z;
    pr_c[0] = in_ch.frame_energy * in_ch.particle_energy;
    pr_c[1] = in_ch.frame_mom_x * in_ch.particle_mom_x;
    pr_c[2] = in_ch.frame_mom_y * in_ch.particle_mom_y;
    pr_c[3] = in_ch.frame_mom_z * in_ch.particle_mom_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r     <= in_ch.valid;
      s1_part_r    <= '{in_ch.particle_energy, in_ch.particle_mom_x,
                        in_ch.particle_mom_y, in_ch.particle_mom_z};
      s1_frame_r   <= '{in_ch.frame_energy, in_ch.frame_mom_x,
                        in_ch.frame_mom_y, in_ch.frame_mom_z};
      for (int i = 0; i < 4; i++) begin
        s1_sq_r[i] <= sq_c[i][62:0];
        s1_pr_r[i] <= pr_c[i];
      end
    end
  end

  // Stage 2: norms, dot product, energy numerator, frame flags
  logic                  s2_vld_r;
  lbfv_pkg::sq_side_t    s2_side_r;
  logic [RIN_W-1:0]      s2_rad_r [2];
  logic [RIN_W-1:0]      p2_c, e2_c;
  logic                  spacelike_c;
  lbfv_pkg::sq_side_t    s2_side_c;

  always_comb begin
    p2_c        = RIN_W'(s1_sq_r[1]) + RIN_W'(s1_sq_r[2]) + RIN_W'(s1_sq_r[3]);
    e2_c        = RIN_W'(s1_sq_r[0]);
    spacelike_c = p2_c >= e2_c;
    s2_side_c.part      = s1_part_r;
    s2_side_c.frame     = s1_frame_r;
    s2_side_c.dot       = DOT_W'(s1_pr_r[1]) + DOT_W'(s1_pr_r[2]) + DOT_W'(s1_pr_r[3]);
    s2_side_c.nume      = DOT_W'(s1_pr_r[0]) - DOT_W'(s1_pr_r[1])
                        - DOT_W'(s1_pr_r[2]) - DOT_W'(s1_pr_r[3]);
    s2_side_c.ef_pos    = !s1_frame_r.e[31] && (s1_frame_r.e != '0);
    s2_side_c.spacelike = spacelike_c;
    s2_side_c.rest      = (s1_frame_r.x == '0) && (s1_frame_r.y == '0)
                       && (s1_frame_r.z == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r    <= s1_vld_r;
      s2_side_r   <= s2_side_c;
      s2_rad_r[0] <= p2_c;
      s2_rad_r[1] <= spacelike_c ? '0 : e2_c - p2_c;
    end
  end

  // Momentum magnitude and frame mass roots
  logic                              sq_vld;
  logic [lbfv_pkg::ROOT_W-1:0]       sq_root [2];
  logic [$bits(lbfv_pkg::sq_side_t)-1:0] sq_side_vec;
  lbfv_pkg::sq_side_t                sq_side;

  lbfv_sqrt_pipe #(
    .LANES  (2),
    .SIDE_W ($bits(lbfv_pkg::sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_vld_r),
    .in_rad    (s2_rad_r),
    .in_side   (s2_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side_vec)
  );

  assign sq_side = lbfv_pkg::sq_side_t'(sq_side_vec);

  // Stage 3: classify frame, form boost denominator
  logic                       s3_vld_r;
  lbfv_pkg::da_side_t         s3_side_r;
  logic signed [DOT_W-1:0]    s3_dot_r [1];
  logic [DEN_W-1:0]           s3_den_r;
  logic signed [33:0]         diff_c;
  logic [33:0]                adiff_c;
  lbfv_pkg::status_t          st_c;

  always_comb begin
    diff_c  = 34'(sq_side.frame.e) - $signed({2'b00, sq_root[0]});
    adiff_c = diff_c[33] ? 34'(-diff_c) : 34'(diff_c);
    priority if (!sq_side.ef_pos) begin
      st_c = lbfv_pkg::ST_MASSLESS;
    end else if (sq_side.spacelike || adiff_c <= 34'(tol_r)) begin
      st_c = lbfv_pkg::ST_MASSLESS;
    end else if (sq_side.rest) begin
      st_c = lbfv_pkg::ST_REST;
    end else begin
      st_c = lbfv_pkg::ST_BOOST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r       <= sq_vld;
      s3_side_r.part <= sq_side.part;
      s3_side_r.fx   <= sq_side.frame.x;
      s3_side_r.fy   <= sq_side.frame.y;
      s3_side_r.fz   <= sq_side.frame.z;
      s3_side_r.nume <= sq_side.nume;
      s3_side_r.m    <= sq_root[1];
      s3_side_r.st   <= st_c;
      s3_dot_r[0]    <= sq_side.dot;
      s3_den_r       <= sq_side.frame.e[DEN_W-1:0] + sq_root[1];
    end
  end

  // Dot product over (Ef + m)
  logic                                   da_vld;
  logic signed [QUO_W:0]                  da_quo [1];
  logic [$bits(lbfv_pkg::da_side_t)-1:0]  da_side_vec;
  lbfv_pkg::da_side_t                     da_side;

  lbfv_div_pipe #(
    .LANES  (1),
    .NUM_W  (DOT_W),
    .SIDE_W ($bits(lbfv_pkg::da_side_t))
  ) u_div_inner (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_num    (s3_dot_r),
    .in_den    (s3_den_r),
    .in_side   (s3_side_r),
    .out_valid (da_vld),
    .out_quo   (da_quo),
    .out_side  (da_side_vec)
  );

  assign da_side = lbfv_pkg::da_side_t'(da_side_vec);

  // Stage 4: inner factor
  logic                        s4_vld_r;
  lbfv_pkg::da_side_t          s4_side_r;
  logic signed [INNER_W-1:0]   s4_inner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r   <= da_vld;
      s4_side_r  <= da_side;
      s4_inner_r <= INNER_W'(da_quo[0]) - INNER_W'(da_side.part.e);
    end
  end

  // Stage 5: frame component times inner, split in two partial products
  logic                     s5_vld_r;
  lbfv_pkg::da_side_t       s5_side_r;
  logic signed [PL_W-1:0]   s5_pl_r [3];
  logic signed [PH_W-1:0]   s5_ph_r [3];
  logic signed [SPLIT:0]              lo_c;
  logic signed [INNER_W-SPLIT-1:0]    hi_c;
  lbfv_pkg::fix_t                     fr_c [3];
  logic signed [PL_W-1:0]             pl_c [3];
  logic signed [PH_W-1:0]             ph_c [3];

  always_comb begin
    lo_c    = {1'b0, s4_inner_r[SPLIT-1:0]};
    hi_c    = s4_inner_r[INNER_W-1:SPLIT];
    fr_c[0] = s4_side_r.fx;
    fr_c[1] = s4_side_r.fy;
    fr_c[2] = s4_side_r.fz;
    for (int i = 0; i < 3; i++) begin
      pl_c[i] = fr_c[i] * lo_c;
      ph_c[i] = fr_c[i] * hi_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r  <= s4_vld_r;
      s5_side_r <= s4_side_r;
      s5_pl_r   <= pl_c;
      s5_ph_r   <= ph_c;
    end
  end

  // Stage 6: combine partial products, line up the four numerators
  logic                        s6_vld_r;
  lbfv_pkg::db_side_t          s6_side_r;
  logic signed [PROD_W-1:0]    s6_num_r [4];
  logic [DEN_W-1:0]            s6_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r       <= s5_vld_r;
      s6_side_r.part <= s5_side_r.part;
      s6_side_r.st   <= s5_side_r.st;
      s6_den_r       <= s5_side_r.m;
      s6_num_r[0]    <= PROD_W'(s5_side_r.nume);
      for (int i = 0; i < 3; i++) begin
        s6_num_r[i+1] <= (PROD_W'(s5_ph_r[i]) <<< SPLIT) + PROD_W'(s5_pl_r[i]);
      end
    end
  end

  // Boosted energy and momentum corrections over m
  logic                                   db_vld;
  logic signed [QUO_W:0]                  db_quo [4];
  logic [$bits(lbfv_pkg::db_side_t)-1:0]  db_side_vec;
  lbfv_pkg::db_side_t                     db_side;

  lbfv_div_pipe #(
    .LANES  (4),
    .NUM_W  (PROD_W),
    .SIDE_W ($bits(lbfv_pkg::db_side_t))
  ) u_div_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s6_vld_r),
    .in_num    (s6_num_r),
    .in_den    (s6_den_r),
    .in_side   (s6_side_r),
    .out_valid (db_vld),
    .out_quo   (db_quo),
    .out_side  (db_side_vec)
  );

  assign db_side = lbfv_pkg::db_side_t'(db_side_vec);

  // Output register: add, saturate, or pass through
  lbfv_pkg::fvec_t            out_vec_r;
  lbfv_pkg::status_t          out_st_r;
  logic signed [SUM_W-1:0]    sum_c [4];
  logic                       any_sat_c;

  always_comb begin
    sum_c[0] = SUM_W'(db_quo[0]);
    sum_c[1] = SUM_W'(db_side.part.x) + SUM_W'(db_quo[1]);
    sum_c[2] = SUM_W'(db_side.part.y) + SUM_W'(db_quo[2]);
    sum_c[3] = SUM_W'(db_side.part.z) + SUM_W'(db_quo[3]);
    any_sat_c = lbfv_pkg::sat_hit(sum_c[0]) || lbfv_pkg::sat_hit(sum_c[1])
             || lbfv_pkg::sat_hit(sum_c[2]) || lbfv_pkg::sat_hit(sum_c[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= db_vld;
      if (db_side.st == lbfv_pkg::ST_BOOST) begin
        out_vec_r.e <= lbfv_pkg::sat_clip(sum_c[0]);
        out_vec_r.x <= lbfv_pkg::sat_clip(sum_c[1]);
        out_vec_r.y <= lbfv_pkg::sat_clip(sum_c[2]);
        out_vec_r.z <= lbfv_pkg::sat_clip(sum_c[3]);
        out_st_r    <= any_sat_c ? lbfv_pkg::ST_SAT : lbfv_pkg::ST_BOOST;
      end else begin
        out_vec_r   <= db_side.part;
        out_st_r    <= db_side.st;
      end
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.boosted_energy = out_vec_r.e;
  assign out_ch.boosted_mom_x  = out_vec_r.x;
  assign out_ch.boosted_mom_y  = out_vec_r.y;
  assign out_ch.boosted_mom_z  = out_vec_r.z;
  assign out_ch.status         = out_st_r;

endmodule
